// ----- hw/rtl/cwm_pkg.sv -----
package cwm_pkg;

    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 6;
    localparam int IDX_IN_W   = 4;
    localparam int COUNT_W    = 5;
    localparam int ENTRY_W    = ADDR_W + LEN_W;
    localparam logic [LEN_W-1:0] MAX_PREFIX = 6'd32;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic {
        CMD_LOAD,
        CMD_LOOKUP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [IDX_IN_W-1:0]   entry_index;
        logic [ADDR_W-1:0]     address;
        logic [LEN_W-1:0]      prefix_length;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } t_back_state;

    // Mask with the top len bits set; len is at most 32.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] ones;
        ones = '1;
        return ~(ones >> len);
    endfunction

endpackage

// ----- hw/rtl/cwm_ram.sv -----
module cwm_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/cwm_front.sv -----
module cwm_front #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [cwm_pkg::IDX_IN_W-1:0]  i_entry_index,
    input  logic [cwm_pkg::ADDR_W-1:0]    i_address,
    input  logic [cwm_pkg::LEN_W-1:0]     i_prefix_length,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cwm_pkg::COUNT_W-1:0]   i_cfg_data,
    input  logic                          i_q_full,
    output logic                          o_push,
    output cwm_pkg::t_cmd                 o_cmd,
    output logic [cwm_pkg::COUNT_W-1:0]   o_entry_count
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PAD_W = IDX_W + cwm_pkg::IDX_IN_W;

    logic [cwm_pkg::COUNT_W-1:0] r_entry_count;
    logic [PAD_W-1:0]            wide_index;
    logic                        index_ok;
    logic                        accept;

    assign busy        = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !i_q_full;

    assign wide_index = {{IDX_W{1'b0}}, i_entry_index};
    assign index_ok   = wide_index < PAD_W'(TABLE_DEPTH);

    // Loads aimed past the end of the table are dropped here.
    always_comb begin
        o_cmd.kind          = (i_mode == cwm_pkg::MODE_LOOKUP) ? cwm_pkg::CMD_LOOKUP
                                                               : cwm_pkg::CMD_LOAD;
        o_cmd.entry_index   = i_entry_index;
        o_cmd.address       = i_address;
        o_cmd.prefix_length = (i_prefix_length > cwm_pkg::MAX_PREFIX) ? cwm_pkg::MAX_PREFIX
                                                                       : i_prefix_length;
        o_push = accept && ((i_mode == cwm_pkg::MODE_LOOKUP) || index_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid) begin
            r_entry_count <= i_cfg_data;
        end
    end

    assign o_entry_count = r_entry_count;

endmodule

// ----- hw/rtl/cwm_cmd_queue.sv -----
module cwm_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cwm_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output cwm_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);

    cwm_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_fill;
    logic          do_push;
    logic          do_pop;

    assign o_full  = r_fill == 2'd2;
    assign o_empty = r_fill == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// ----- hw/rtl/cwm_back.sv -----
module cwm_back #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cwm_pkg::t_cmd                 i_head,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    input  logic [cwm_pkg::COUNT_W-1:0]   i_entry_count,
    output logic                          o_result_strobe,
    output logic                          o_trusted,
    output logic [cwm_pkg::IDX_IN_W-1:0]  o_match_index
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int PAD_W = IDX_W + cwm_pkg::IDX_IN_W;
    localparam int CMP_W = CNT_W + cwm_pkg::COUNT_W;
    localparam int MI_W  = CNT_W + cwm_pkg::IDX_IN_W;

    cwm_pkg::t_back_state r_state, n_state;
    logic [cwm_pkg::ADDR_W-1:0]   r_key, n_key;
    logic [CNT_W-1:0]             r_limit, n_limit;
    logic [CNT_W-1:0]             r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]             r_cmp_idx, n_cmp_idx;
    logic                         r_cmp_vld, n_cmp_vld;
    logic                         r_res_strobe, n_res_strobe;
    logic                         r_trusted, n_trusted;
    logic [cwm_pkg::IDX_IN_W-1:0] r_match_index, n_match_index;

    logic                         ram_we;
    logic                         ram_re;
    logic [PAD_W-1:0]             wide_windex;
    logic [cwm_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [cwm_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [cwm_pkg::ADDR_W-1:0]   entry_addr;
    logic [cwm_pkg::LEN_W-1:0]    entry_len;
    logic                         hit;
    logic                         last;
    logic [CMP_W-1:0]             count_wide;
    logic [CMP_W-1:0]             depth_wide;
    logic [CNT_W-1:0]             limit;
    logic [MI_W-1:0]              wide_cmp_idx;

    assign wide_windex = {{IDX_W{1'b0}}, i_head.entry_index};
    assign ram_wdata   = {i_head.address, i_head.prefix_length};

    cwm_ram #(
        .WIDTH (cwm_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wide_windex[IDX_W-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign entry_addr = ram_rdata[cwm_pkg::ENTRY_W-1:cwm_pkg::LEN_W];
    assign entry_len  = ram_rdata[cwm_pkg::LEN_W-1:0];
    assign hit = ((r_key ^ entry_addr) & cwm_pkg::prefix_mask(entry_len)) == '0;
    assign last = (r_cmp_idx + CNT_W'(1)) == r_limit;

    assign count_wide   = {{CNT_W{1'b0}}, i_entry_count};
    assign depth_wide   = CMP_W'(TABLE_DEPTH);
    assign limit        = (count_wide > depth_wide) ? depth_wide[CNT_W-1:0]
                                                    : count_wide[CNT_W-1:0];
    assign wide_cmp_idx = {{cwm_pkg::IDX_IN_W{1'b0}}, r_cmp_idx};

    // The scan reads one entry per cycle and compares it in the next.
    always_comb begin
        n_state       = r_state;
        n_key         = r_key;
        n_limit       = r_limit;
        n_rd_idx      = r_rd_idx;
        n_cmp_idx     = r_cmp_idx;
        n_cmp_vld     = 1'b0;
        n_res_strobe  = 1'b0;
        n_trusted     = 1'b0;
        n_match_index = '0;
        o_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        case (r_state)
            cwm_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_head.kind == cwm_pkg::CMD_LOAD) begin
                        ram_we = 1'b1;
                    end else if (limit == '0) begin
                        n_res_strobe = 1'b1;
                    end else begin
                        n_state  = cwm_pkg::BK_SCAN;
                        n_key    = i_head.address;
                        n_limit  = limit;
                        n_rd_idx = '0;
                    end
                end
            end
            cwm_pkg::BK_SCAN: begin
                if (r_rd_idx < r_limit) begin
                    ram_re    = 1'b1;
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx;
                end
                if (r_cmp_vld && (hit || last)) begin
                    n_state       = cwm_pkg::BK_IDLE;
                    n_cmp_vld     = 1'b0;
                    n_res_strobe  = 1'b1;
                    n_trusted     = hit;
                    n_match_index = hit ? wide_cmp_idx[cwm_pkg::IDX_IN_W-1:0] : '0;
                end
            end
            default: begin
                n_state = cwm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cwm_pkg::BK_IDLE;
            r_cmp_vld    <= 1'b0;
            r_res_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cmp_vld    <= n_cmp_vld;
            r_res_strobe <= n_res_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_limit       <= n_limit;
        r_rd_idx      <= n_rd_idx;
        r_cmp_idx     <= n_cmp_idx;
        r_trusted     <= n_trusted;
        r_match_index <= n_match_index;
    end

    assign o_result_strobe = r_res_strobe;
    assign o_trusted       = r_trusted;
    assign o_match_index   = r_match_index;

`ifndef NO_ASSERTIONS
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cwm_pkg::BK_SCAN) |-> (r_rd_idx <= r_limit))
        else $error("scan read index ran past the active count");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_cmp_idx < r_limit))
        else $error("compared entry lies outside the active range");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_strobe |-> (r_state == cwm_pkg::BK_IDLE))
        else $error("result issued while a scan is still running");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_strobe && !r_trusted) |-> (r_match_index == '0))
        else $error("untrusted result carries a nonzero index");

    a_no_pop_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cwm_pkg::BK_SCAN) |-> !o_pop)
        else $error("queue popped during a scan");
`endif

endmodule

// ----- hw/rtl/cidr_whitelist_match_core.sv -----
// Channel    Direction  Handshake                     Word
// input      in         start / busy                  i_mode, i_entry_index, i_address,
//                                                     i_prefix_length
// result     out        o_result_strobe (one cycle)   o_trusted, o_match_index
// config     in         i_cfg_valid / o_cfg_ready     i_cfg_data (entry_count)
//
// A two-word queue separates acceptance from execution; busy is high while it is full.
// A load occupies the table port for one cycle. A lookup scans the active entries in
// index order through the single read port of the entry table, one entry per cycle,
// and its result strobe is registered from the compare that hits or reaches the last
// active entry; with no active entries the strobe follows the pop in the next cycle.
// Reset is synchronous and active low; the table contents are not cleared.
// Results cannot be stalled by the receiver.
module cidr_whitelist_match_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [cwm_pkg::IDX_IN_W-1:0]  i_entry_index,
    input  logic [cwm_pkg::ADDR_W-1:0]    i_address,
    input  logic [cwm_pkg::LEN_W-1:0]     i_prefix_length,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cwm_pkg::COUNT_W-1:0]   i_cfg_data,
    output logic                          o_result_strobe,
    output logic                          o_trusted,
    output logic [cwm_pkg::IDX_IN_W-1:0]  o_match_index
);

    logic                        q_full;
    logic                        q_empty;
    logic                        push;
    logic                        pop;
    cwm_pkg::t_cmd               push_cmd;
    cwm_pkg::t_cmd               head_cmd;
    logic [cwm_pkg::COUNT_W-1:0] entry_count;

    cwm_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_entry_index   (i_entry_index),
        .i_address       (i_address),
        .i_prefix_length (i_prefix_length),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .o_entry_count   (entry_count)
    );

    cwm_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cwm_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_cmd),
        .i_q_empty       (q_empty),
        .o_pop           (pop),
        .i_entry_count   (entry_count),
        .o_result_strobe (o_result_strobe),
        .o_trusted       (o_trusted),
        .o_match_index   (o_match_index)
    );

endmodule

// ----- tb/sv/cidr_whitelist_match_checker.sv -----
`timescale 1ns / 100ps
module cidr_whitelist_match_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_mode,
    input  logic [cwm_pkg::IDX_IN_W-1:0]  i_entry_index,
    input  logic [cwm_pkg::ADDR_W-1:0]    i_address,
    input  logic [cwm_pkg::LEN_W-1:0]     i_prefix_length,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [cwm_pkg::COUNT_W-1:0]   i_cfg_data,
    input  logic                          i_result_strobe,
    input  logic                          i_trusted,
    input  logic [cwm_pkg::IDX_IN_W-1:0]  i_match_index,
    output int                            o_mismatches,
    output int                            o_outstanding
);

    typedef struct packed {
        logic                         trusted;
        logic [cwm_pkg::IDX_IN_W-1:0] match_index;
    } t_verdict;

    logic [cwm_pkg::ADDR_W-1:0]  allow_addr [TABLE_DEPTH];
    logic [cwm_pkg::LEN_W-1:0]   allow_len  [TABLE_DEPTH];
    logic [cwm_pkg::COUNT_W-1:0] active_count = '0;
    t_verdict                    expected_verdicts [$];
    int                          mismatch_count = 0;
    t_verdict                    got;
    t_verdict                    want;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // Scans the active entries in index order and returns the first prefix hit.
    function automatic t_verdict match_lookup(input logic [cwm_pkg::ADDR_W-1:0] addr);
        t_verdict                   v;
        int                         limit;
        logic [cwm_pkg::ADDR_W-1:0] keep;
        v = '0;
        limit = (int'(active_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
        for (int k = 0; k < limit; k++) begin
            keep = ~({cwm_pkg::ADDR_W{1'b1}} >> allow_len[k]);
            if (((addr ^ allow_addr[k]) & keep) == '0) begin
                v.trusted     = 1'b1;
                v.match_index = k[cwm_pkg::IDX_IN_W-1:0];
                return v;
            end
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            active_count = '0;
            expected_verdicts.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                active_count = i_cfg_data;
            end
            if (i_result_strobe) begin
                got.trusted     = i_trusted;
                got.match_index = i_match_index;
                if (expected_verdicts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected result word, trusted %0b index %0d",
                                 $realtime, got.trusted, got.match_index);
                    end
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.trusted !== want.trusted
                            || got.match_index !== want.match_index) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: result word trusted %0b index %0d, expected %0b %0d",
                                     $realtime, got.trusted, got.match_index,
                                     want.trusted, want.match_index);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (cwm_pkg::t_cmd_kind'(i_mode) == cwm_pkg::CMD_LOAD) begin
                    if (int'(i_entry_index) < TABLE_DEPTH) begin
                        allow_addr[i_entry_index] = i_address;
                        allow_len[i_entry_index]  =
                            (i_prefix_length > cwm_pkg::MAX_PREFIX) ?
                            cwm_pkg::MAX_PREFIX : i_prefix_length;
                    end
                end else begin
                    expected_verdicts.push_back(match_lookup(i_address));
                end
            end
        end
        o_outstanding <= expected_verdicts.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

// ----- tb/sv/tb_cidr_whitelist_match_core.sv -----
`timescale 1ns / 100ps
module tb_cidr_whitelist_match_core;

    localparam int TABLE_DEPTH  = 16;
    localparam int DRAIN_CYCLES = 64;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          start           = 1'b0;
    logic                          busy;
    logic                          i_mode          = cwm_pkg::MODE_LOAD;
    logic [cwm_pkg::IDX_IN_W-1:0]  i_entry_index   = '0;
    logic [cwm_pkg::ADDR_W-1:0]    i_address       = '0;
    logic [cwm_pkg::LEN_W-1:0]     i_prefix_length = '0;
    logic                          i_cfg_valid     = 1'b0;
    logic                          o_cfg_ready;
    logic [cwm_pkg::COUNT_W-1:0]   i_cfg_data      = '0;
    logic                          o_result_strobe;
    logic                          o_trusted;
    logic [cwm_pkg::IDX_IN_W-1:0]  o_match_index;
    int                            mismatches;
    int                            outstanding;

    logic [cwm_pkg::ADDR_W-1:0]    shadow_addr [TABLE_DEPTH];
    logic [cwm_pkg::LEN_W-1:0]     shadow_len  [TABLE_DEPTH];
    bit                            quiet = 1'b0;

    cidr_whitelist_match_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_mode(i_mode),
        .i_entry_index(i_entry_index),
        .i_address(i_address),
        .i_prefix_length(i_prefix_length),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .o_result_strobe(o_result_strobe),
        .o_trusted(o_trusted),
        .o_match_index(o_match_index)
    );

    cidr_whitelist_match_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_mode(i_mode),
        .i_entry_index(i_entry_index),
        .i_address(i_address),
        .i_prefix_length(i_prefix_length),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .i_result_strobe(o_result_strobe),
        .i_trusted(o_trusted),
        .i_match_index(o_match_index),
        .o_mismatches(mismatches),
        .o_outstanding(outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // Holds start high with a new word until the block takes it.
    task automatic issue_word(input logic mode_bit,
                              input logic [cwm_pkg::IDX_IN_W-1:0] idx,
                              input logic [cwm_pkg::ADDR_W-1:0] addr,
                              input logic [cwm_pkg::LEN_W-1:0] len);
        start           <= 1'b1;
        i_mode          <= mode_bit;
        i_entry_index   <= idx;
        i_address       <= addr;
        i_prefix_length <= len;
        do @(posedge i_clk); while (busy);
        if (mode_bit == cwm_pkg::MODE_LOAD) begin
            shadow_addr[idx] = addr;
            shadow_len[idx]  = (len > cwm_pkg::MAX_PREFIX) ? cwm_pkg::MAX_PREFIX : len;
        end
    endtask

    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) begin
            n = 0;
        end else if (r < 95) begin
            n = $urandom_range(1, 3);
        end else begin
            n = $urandom_range(8, 40);
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic lookup(input logic [cwm_pkg::ADDR_W-1:0] addr);
        issue_word(cwm_pkg::MODE_LOOKUP, cwm_pkg::IDX_IN_W'($urandom_range(0, 15)), addr,
                   cwm_pkg::LEN_W'($urandom_range(0, 63)));
        idle_gap();
    endtask

    task automatic load(input int slot, input logic [cwm_pkg::ADDR_W-1:0] addr,
                        input int len);
        issue_word(cwm_pkg::MODE_LOAD, cwm_pkg::IDX_IN_W'(slot), addr,
                   cwm_pkg::LEN_W'(len));
        idle_gap();
    endtask

    // Loads still in flight give no result, so the drain covers them too.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input int count);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cwm_pkg::COUNT_W'(count);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_word();
        int                         r;
        int                         k;
        int                         len;
        logic [cwm_pkg::ADDR_W-1:0] addr;
        logic [cwm_pkg::ADDR_W-1:0] keep;
        r    = $urandom_range(0, 99);
        k    = $urandom_range(0, TABLE_DEPTH - 1);
        addr = $urandom();
        if (r < 30) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                len = 0;
            end else if (r < 14) begin
                len = $urandom_range(33, 63);
            end else if (r < 34) begin
                len = 32;
            end else begin
                len = $urandom_range(1, 32);
            end
            if ($urandom_range(0, 3) == 0) begin
                addr = shadow_addr[$urandom_range(0, TABLE_DEPTH - 1)];
            end
            load(k, addr, len);
        end else begin
            keep = ~({cwm_pkg::ADDR_W{1'b1}} >> shadow_len[k]);
            if (r < 70) begin
                addr = (shadow_addr[k] & keep) | (addr & ~keep);
            end else if (r < 82 && shadow_len[k] != 0) begin
                addr = shadow_addr[k]
                       ^ (32'h8000_0000 >> $urandom_range(0, int'(shadow_len[k]) - 1));
            end
            lookup(addr);
        end
    endtask

    initial begin : stimulus
        int counts [8];
        int n;
        counts = '{31, 0, 1, 16, 17, 8, 2, 12};
        counts[5] = $urandom_range(2, 15);
        counts[7] = $urandom_range(0, 31);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        lookup(32'h0000_0000);
        lookup(32'hFFFF_FFFF);
        load(0, 32'hC0A8_0000, 16);
        load(1, 32'h0A00_0000, 8);
        load(2, 32'hFFFF_FFFF, 32);
        load(3, 32'h0000_0000, 32);
        load(4, 32'h1234_5678, 40);
        load(5, 32'hAC10_0000, 12);
        for (int s = 6; s < TABLE_DEPTH - 1; s++) begin
            load(s, $urandom(), $urandom_range(24, 32));
        end
        load(TABLE_DEPTH - 1, 32'h0000_0000, 0);
        settle();
        write_count(TABLE_DEPTH);
        lookup(32'hC0A8_1234);
        lookup(32'h0AFF_FFFF);
        lookup(32'hFFFF_FFFF);
        lookup(32'h0000_0000);
        lookup(32'h1234_5678);
        lookup(32'h1234_5679);

        foreach (counts[p]) begin
            settle();
            write_count(counts[p]);
            quiet = (p % 3 == 1);
            n = $urandom_range(60, 72);
            repeat (n) random_word();
        end

        settle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cwm_pkg.sv
hw/rtl/cwm_ram.sv
hw/rtl/cwm_front.sv
hw/rtl/cwm_cmd_queue.sv
hw/rtl/cwm_back.sv
hw/rtl/cidr_whitelist_match_core.sv
tb/sv/cidr_whitelist_match_checker.sv
tb/sv/tb_cidr_whitelist_match_core.sv
